// ===== rtl/sle_pkg.sv =====
// Shared constants and codes for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

	// List geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Port field widths
	localparam int OP_W        = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int FIDX_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND,
		OP_PREPEND,
		OP_POP_FIRST,
		OP_POP_LAST,
		OP_INSERT,
		OP_FIND,
		OP_SORT,
		OP_CLEAR
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY,
		ST_BAD_POS
	} status_t;

endpackage

// ===== rtl/sequential_list_engine_unit.sv =====
// Bounded ordered list of signed words kept in one synchronous memory.
`timescale 1ns / 1ps

// Append, pop last, clear and rejected requests go from idle straight to the result state;
// prepend or insert inside the list and pop first shift entries, find walks up to count
// entries and a sort of two or more entries runs bubble passes. One request is worked at
// a time, so a new word is taken once the result is loaded; the memory walks one entry per
// cycle and a finished result waits in the output register meanwhile.
// Reset clears state, count, walk counter and output valid at once; data and memory are not cleared.
module sequential_list_engine_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // value[31:0], position[39:32]
	input  logic [sle_pkg::OP_W-1:0]         s_axis_tuser,  // operation[2:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // found[0], found_index[6:1],
	                                                        // count[13:7], zero[15:14]
	output logic [sle_pkg::STATUS_W-1:0]     m_axis_tuser   // status[1:0]
);

	localparam int IDX_W = sle_pkg::IDX_W;
	localparam int CNT_W = sle_pkg::CNT_W;
	localparam int DW    = sle_pkg::DATA_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_FIND,
		S_SORT_LOAD,
		S_SORT_HOLD,
		S_SORT_RUN,
		S_RESULT
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DW-1:0]         word_q;
	logic [IDX_W-1:0]      pos_q;
	logic                  up_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic [CNT_W-1:0]      left_q;
	logic                  pend_s1;
	logic [IDX_W-1:0]      wa_s1;
	logic [DW-1:0]         hold_q;
	logic [IDX_W-1:0]      lim_q;
	sle_pkg::status_t      res_status_q;
	logic                  res_found_q;
	logic [IDX_W-1:0]      res_fidx_q;
	logic                  m_valid_q;
	logic [sle_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic [sle_pkg::STATUS_W-1:0]    m_tuser_q;

	// Entry memory
	logic [DW-1:0]    mem [sle_pkg::DEPTH];
	logic [DW-1:0]    rd_data_q;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [DW-1:0]    wr_data;

	// Input decode
	logic                            accept;
	sle_pkg::op_t                    op_in;
	logic signed [sle_pkg::VALUE_W-1:0] value_in;
	logic [sle_pkg::POS_W-1:0]       pos_in;
	logic [sle_pkg::POS_W-1:0]       ins_pos;
	logic [DW-1:0]                   word_in;
	logic                            full;
	logic                            empty;
	logic                            pos_bad;
	logic                            pos_inside;
	logic                            is_insert;
	logic                            issue;
	logic                            gt;
	logic                            out_free;
	sle_pkg::status_t                idle_status;
	state_t                          idle_next;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op_in         = sle_pkg::op_t'(s_axis_tuser);
	assign value_in      = s_axis_tdata[sle_pkg::VALUE_W-1:0];
	assign pos_in        = s_axis_tdata[sle_pkg::VALUE_W +: sle_pkg::POS_W];
	assign word_in       = DW'(value_in);
	assign is_insert     = (op_in == sle_pkg::OP_INSERT) || (op_in == sle_pkg::OP_PREPEND);
	assign ins_pos       = (op_in == sle_pkg::OP_PREPEND) ? '0 : pos_in;
	assign full          = (int'(cnt_q) >= sle_pkg::DEPTH);
	assign empty         = (cnt_q == '0);
	assign pos_bad       = (int'(ins_pos) >= sle_pkg::DEPTH);
	assign pos_inside    = (int'(ins_pos) < int'(cnt_q));
	assign issue         = (left_q != '0);
	assign gt            = $signed(hold_q) > $signed(rd_data_q);
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	// Request outcome: result status and the state that works it
	always_comb begin
		idle_status = sle_pkg::ST_OK;
		idle_next   = S_RESULT;
		unique case (op_in)
			sle_pkg::OP_APPEND: begin
				if (full) begin
					idle_status = sle_pkg::ST_FULL;
				end
			end
			sle_pkg::OP_PREPEND, sle_pkg::OP_INSERT: begin
				if (full) begin
					idle_status = sle_pkg::ST_FULL;
				end else if (pos_bad) begin
					idle_status = sle_pkg::ST_BAD_POS;
				end else if (pos_inside) begin
					idle_next = S_SHIFT;
				end
			end
			sle_pkg::OP_POP_FIRST: begin
				if (empty) begin
					idle_status = sle_pkg::ST_EMPTY;
				end else begin
					idle_next = S_SHIFT;
				end
			end
			sle_pkg::OP_POP_LAST: begin
				if (empty) begin
					idle_status = sle_pkg::ST_EMPTY;
				end
			end
			sle_pkg::OP_FIND: begin
				if (empty) begin
					idle_status = sle_pkg::ST_EMPTY;
				end else begin
					idle_next = S_FIND;
				end
			end
			sle_pkg::OP_SORT: begin
				if (empty) begin
					idle_status = sle_pkg::ST_EMPTY;
				end else if (cnt_q != CNT_W'(1)) begin
					idle_next = S_SORT_LOAD;
				end
			end
			sle_pkg::OP_CLEAR: begin
				idle_status = sle_pkg::ST_OK;
			end
		endcase
	end

	// Memory write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_q;
		wr_data = rd_data_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !full &&
				    ((op_in == sle_pkg::OP_APPEND) ||
				     (is_insert && !pos_bad && !pos_inside))) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(cnt_q);
					wr_data = word_in;
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = wa_s1;
					wr_data = rd_data_q;
				end else if (!issue && up_q) begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
					wr_data = word_q;
				end
			end
			S_SORT_RUN: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = wa_s1;
					wr_data = gt ? rd_data_q : hold_q;
				end else if (!issue) begin
					wr_en   = 1'b1;
					wr_addr = lim_q;
					wr_data = hold_q;
				end
			end
			S_FIND, S_SORT_LOAD, S_SORT_HOLD, S_RESULT: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr_q];
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			left_q    <= '0;
			pend_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// Load the output register from a finished request, drop it once taken
			if ((state_q == S_RESULT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						word_q       <= word_in;
						pos_q        <= IDX_W'(ins_pos);
						pend_s1      <= 1'b0;
						res_status_q <= idle_status;
						res_found_q  <= 1'b0;
						res_fidx_q   <= '0;
						state_q      <= idle_next;
						unique case (op_in)
							sle_pkg::OP_APPEND: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							sle_pkg::OP_PREPEND, sle_pkg::OP_INSERT: begin
								if (!full && !pos_bad) begin
									if (pos_inside) begin
										// open a hole at the position, top entry first
										up_q      <= 1'b1;
										rd_addr_q <= IDX_W'(cnt_q - 1'b1);
										left_q    <= cnt_q - CNT_W'(ins_pos);
									end else begin
										cnt_q <= cnt_q + 1'b1;
									end
								end
							end
							sle_pkg::OP_POP_FIRST: begin
								if (!empty) begin
									up_q      <= 1'b0;
									rd_addr_q <= IDX_W'(1);
									left_q    <= cnt_q - 1'b1;
								end
							end
							sle_pkg::OP_POP_LAST: begin
								if (!empty) begin
									cnt_q <= cnt_q - 1'b1;
								end
							end
							sle_pkg::OP_FIND: begin
								if (!empty) begin
									rd_addr_q <= '0;
									left_q    <= cnt_q;
								end
							end
							sle_pkg::OP_SORT: begin
								if (!empty && (cnt_q != CNT_W'(1))) begin
									lim_q     <= IDX_W'(cnt_q - 1'b1);
									rd_addr_q <= '0;
								end
							end
							sle_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
						endcase
					end
				end

				// Move one entry per cycle; write lands in the cycle after its read
				S_SHIFT: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_addr_q <= up_q ? rd_addr_q - 1'b1 : rd_addr_q + 1'b1;
						wa_s1     <= up_q ? rd_addr_q + 1'b1 : rd_addr_q - 1'b1;
						left_q    <= left_q - 1'b1;
					end
					if (!issue && !pend_s1) begin
						cnt_q   <= up_q ? cnt_q + 1'b1 : cnt_q - 1'b1;
						state_q <= S_RESULT;
					end
				end

				// Walk up from entry zero, stop at the first match
				S_FIND: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						wa_s1     <= rd_addr_q;
						left_q    <= left_q - 1'b1;
					end
					if (pend_s1 && (rd_data_q == word_q)) begin
						res_found_q <= 1'b1;
						res_fidx_q  <= wa_s1;
						state_q     <= S_RESULT;
					end else if (!issue && !pend_s1) begin
						state_q <= S_RESULT;
					end
				end

				// Start of a pass: fetch entry zero into the hold register
				S_SORT_LOAD: begin
					rd_addr_q <= IDX_W'(1);
					state_q   <= S_SORT_HOLD;
				end

				S_SORT_HOLD: begin
					hold_q  <= rd_data_q;
					left_q  <= CNT_W'(lim_q);
					pend_s1 <= 1'b0;
					state_q <= S_SORT_RUN;
				end

				// Carry the largest entry seen so far up to the pass limit
				S_SORT_RUN: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						wa_s1     <= rd_addr_q - 1'b1;
						left_q    <= left_q - 1'b1;
					end
					if (pend_s1 && !gt) begin
						hold_q <= rd_data_q;
					end
					if (!issue && !pend_s1) begin
						if (lim_q == IDX_W'(1)) begin
							state_q <= S_RESULT;
						end else begin
							lim_q     <= lim_q - 1'b1;
							rd_addr_q <= '0;
							state_q   <= S_SORT_LOAD;
						end
					end
				end

				// Hand the result to the output register once it is free
				S_RESULT: begin
					if (out_free) begin
						m_tuser_q <= res_status_q;
						m_tdata_q <= {2'b00,
						              sle_pkg::COUNT_W'(cnt_q),
						              sle_pkg::FIDX_W'(res_fidx_q),
						              res_found_q};
						state_q   <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= sle_pkg::DEPTH)
		else $error("entry count above depth");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q == S_IDLE)) |-> accept)
		else $error("memory write in idle without a request");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && issue && ((state_q == S_SHIFT) || (state_q == S_SORT_RUN)))
		|-> (wr_addr != rd_addr_q))
		else $error("walk reads and writes the same entry");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) || (state_q == S_FIND)) |-> (left_q <= cnt_q))
		else $error("walk length above entry count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESULT) && out_free)
		|=> (m_tdata_q[1 + sle_pkg::FIDX_W +: sle_pkg::COUNT_W]
		     == sle_pkg::COUNT_W'($past(cnt_q))))
		else $error("result count differs from entry count");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sequential list engine stream interface.
`timescale 1ns / 1ps

module testbench;

	// One result word as seen on the master side
	typedef struct packed {
		sle_pkg::status_t               status;
		logic                           found;
		logic [sle_pkg::FIDX_W-1:0]     found_index;
		logic [sle_pkg::COUNT_W-1:0]    count;
	} list_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [sle_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // value[31:0], position[39:32]
	logic [sle_pkg::OP_W-1:0]           s_axis_tuser;   // operation[2:0]
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [sle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // found[0], found_index[6:1],
	                                                    // count[13:7]
	logic [sle_pkg::STATUS_W-1:0]       m_axis_tuser;   // status[1:0]

	// Shadow copy of the list contents
	logic signed [sle_pkg::VALUE_W-1:0] list_mem [sle_pkg::DEPTH+1];
	int                                 list_len;

	list_result_t expected_results [$];
	int           mismatch_count;
	int           items_sent;

	// Sender and receiver pacing controls
	bit tx_gaps_on;
	int tx_burst_left;
	bit rx_stalls_on;
	bit rx_hold_request;
	int rx_hold_left;
	int rx_run_left;
	bit rx_ready_phase;

	sequential_list_engine_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Free-running clock
	always #10 clk = ~clk;

	// Apply one request to the shadow list and return the result it produces
	function automatic list_result_t apply_list_op(sle_pkg::op_t op,
			logic signed [sle_pkg::VALUE_W-1:0] value, logic [sle_pkg::POS_W-1:0] pos);
		list_result_t r;
		int k;
		int pass;
		logic signed [sle_pkg::VALUE_W-1:0] tmp;
		r.status = sle_pkg::ST_OK;
		r.found = 1'b0;
		r.found_index = '0;
		case (op)
			sle_pkg::OP_APPEND: begin
				if (list_len >= sle_pkg::DEPTH) begin
					r.status = sle_pkg::ST_FULL;
				end else begin
					list_mem[list_len] = value;
					list_len++;
				end
			end
			sle_pkg::OP_PREPEND: begin
				if (list_len >= sle_pkg::DEPTH) begin
					r.status = sle_pkg::ST_FULL;
				end else begin
					for (k = list_len; k > 0; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[0] = value;
					list_len++;
				end
			end
			sle_pkg::OP_POP_FIRST: begin
				if (list_len == 0) begin
					r.status = sle_pkg::ST_EMPTY;
				end else begin
					for (k = 0; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
				end
			end
			sle_pkg::OP_POP_LAST: begin
				if (list_len == 0)
					r.status = sle_pkg::ST_EMPTY;
				else
					list_len--;
			end
			sle_pkg::OP_INSERT: begin
				// Full check wins over the position check
				if (list_len >= sle_pkg::DEPTH) begin
					r.status = sle_pkg::ST_FULL;
				end else if (pos >= sle_pkg::DEPTH) begin
					r.status = sle_pkg::ST_BAD_POS;
				end else if (pos < list_len) begin
					for (k = list_len; k > pos; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[pos] = value;
					list_len++;
				end else begin
					list_mem[list_len] = value;
					list_len++;
				end
			end
			sle_pkg::OP_FIND: begin
				if (list_len == 0) begin
					r.status = sle_pkg::ST_EMPTY;
				end else begin
					for (k = 0; k < list_len; k++) begin
						if (!r.found && list_mem[k] == value) begin
							r.found = 1'b1;
							r.found_index = sle_pkg::FIDX_W'(k);
						end
					end
				end
			end
			sle_pkg::OP_SORT: begin
				// Ascending bubble sort on signed values
				if (list_len == 0) begin
					r.status = sle_pkg::ST_EMPTY;
				end else begin
					for (pass = 0; pass + 1 < list_len; pass++) begin
						for (k = 0; k + 1 < list_len - pass; k++) begin
							if (list_mem[k] > list_mem[k+1]) begin
								tmp = list_mem[k];
								list_mem[k] = list_mem[k+1];
								list_mem[k+1] = tmp;
							end
						end
					end
				end
			end
			default: list_len = 0;
		endcase
		r.count = sle_pkg::COUNT_W'(list_len);
		return r;
	endfunction

	// Offer one request word, wait for the handshake, then record its result
	task automatic send_request(sle_pkg::op_t op, logic signed [sle_pkg::VALUE_W-1:0] value,
			logic [sle_pkg::POS_W-1:0] pos);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pos, value};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(apply_list_op(op, value, pos));
		items_sent++;
		// Insert an idle gap at the end of each burst
		gap = 0;
		if (tx_gaps_on) begin
			if (tx_burst_left == 0) begin
				tx_burst_left = $urandom_range(1, 10);
				gap = $urandom_range(1, 6);
			end else begin
				tx_burst_left--;
			end
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Value to store or search for: an existing entry for finds, extremes, a small set for duplicates, or anything
	function automatic logic signed [sle_pkg::VALUE_W-1:0] pick_value(bit for_find);
		int sel;
		sel = $urandom_range(0, 99);
		if (for_find && list_len > 0 && sel < 60)
			return list_mem[$urandom_range(0, list_len - 1)];
		if (sel < 5)
			return {1'b1, {(sle_pkg::VALUE_W-1){1'b0}}};
		if (sel < 10)
			return {1'b0, {(sle_pkg::VALUE_W-1){1'b1}}};
		if (sel < 25)
			return sle_pkg::VALUE_W'($signed($urandom_range(0, 6)) - 3);
		return $urandom;
	endfunction

	// Send one random request; the phase biases toward growing, shrinking or a mix
	task automatic send_random(int phase);
		int sel;
		sle_pkg::op_t op;
		logic [sle_pkg::POS_W-1:0] pos;
		sel = $urandom_range(0, 99);
		case (phase)
			0: op = sel < 30 ? sle_pkg::OP_APPEND : sel < 50 ? sle_pkg::OP_PREPEND :
				sel < 72 ? sle_pkg::OP_INSERT : sel < 84 ? sle_pkg::OP_FIND :
				sel < 90 ? sle_pkg::OP_POP_FIRST : sel < 96 ? sle_pkg::OP_POP_LAST :
				sle_pkg::OP_SORT;
			1: op = sel < 10 ? sle_pkg::OP_APPEND : sel < 15 ? sle_pkg::OP_PREPEND :
				sel < 22 ? sle_pkg::OP_INSERT : sel < 34 ? sle_pkg::OP_FIND :
				sel < 62 ? sle_pkg::OP_POP_FIRST : sel < 92 ? sle_pkg::OP_POP_LAST :
				sle_pkg::OP_SORT;
			default: op = sel < 18 ? sle_pkg::OP_APPEND : sel < 30 ? sle_pkg::OP_PREPEND :
				sel < 48 ? sle_pkg::OP_INSERT : sel < 66 ? sle_pkg::OP_FIND :
				sel < 78 ? sle_pkg::OP_POP_FIRST : sel < 90 ? sle_pkg::OP_POP_LAST :
				sel < 96 ? sle_pkg::OP_SORT : sle_pkg::OP_CLEAR;
		endcase
		sel = $urandom_range(0, 99);
		if (sel < 70)
			pos = sle_pkg::POS_W'($urandom_range(0, list_len));
		else if (sel < 85)
			pos = sle_pkg::POS_W'($urandom_range(
				list_len < sle_pkg::DEPTH ? list_len : sle_pkg::DEPTH - 1,
				sle_pkg::DEPTH - 1));
		else
			pos = sle_pkg::POS_W'($urandom);
		send_request(op, pick_value(op == sle_pkg::OP_FIND), pos);
	endtask

	// Requests on an empty list are all rejected
	task automatic test_empty_list;
		send_request(sle_pkg::OP_POP_FIRST, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_POP_LAST, -32'sd1, 8'd255);
		send_request(sle_pkg::OP_FIND, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_SORT, 32'sd5, 8'd3);
	endtask

	// Extreme values, every insert position class, find hit or miss, then sort, pops and clear
	task automatic test_edge_values;
		send_request(sle_pkg::OP_APPEND, {1'b1, {(sle_pkg::VALUE_W-1){1'b0}}}, 8'd0);
		send_request(sle_pkg::OP_APPEND, {1'b0, {(sle_pkg::VALUE_W-1){1'b1}}}, 8'd255);
		send_request(sle_pkg::OP_PREPEND, -32'sd1, 8'd0);
		send_request(sle_pkg::OP_INSERT, 32'sd7, 8'd0);
		send_request(sle_pkg::OP_INSERT, 32'sd7, 8'd2);
		send_request(sle_pkg::OP_INSERT, 32'sd0, 8'd63);
		send_request(sle_pkg::OP_INSERT, 32'sd9, 8'd64);
		send_request(sle_pkg::OP_INSERT, 32'sd9, 8'd255);
		send_request(sle_pkg::OP_FIND, 32'sd7, 8'd0);
		send_request(sle_pkg::OP_FIND, 32'sd12345, 8'd0);
		send_request(sle_pkg::OP_SORT, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_FIND, {1'b0, {(sle_pkg::VALUE_W-1){1'b1}}}, 8'd0);
		send_request(sle_pkg::OP_POP_FIRST, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_POP_LAST, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_CLEAR, -32'sd1, 8'd170);
		send_request(sle_pkg::OP_FIND, 32'sd0, 8'd85);
	endtask

	// Grow the list to full, then check every add is rejected, a full sort, a find and both pops
	task automatic test_full_list;
		tx_gaps_on = 1'b1;
		while (list_len < sle_pkg::DEPTH)
			send_random(0);
		send_request(sle_pkg::OP_APPEND, 32'sd1, 8'd0);
		send_request(sle_pkg::OP_PREPEND, 32'sd1, 8'd0);
		send_request(sle_pkg::OP_INSERT, 32'sd1, 8'd5);
		send_request(sle_pkg::OP_INSERT, 32'sd1, 8'd200);
		send_request(sle_pkg::OP_SORT, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_FIND, list_mem[sle_pkg::DEPTH-1], 8'd0);
		send_request(sle_pkg::OP_POP_FIRST, 32'sd0, 8'd0);
		send_request(sle_pkg::OP_POP_LAST, 32'sd0, 8'd0);
	endtask

	// Hold the receiver off while the sender keeps offering words
	task automatic test_back_pressure;
		int n;
		tx_gaps_on = 1'b0;
		rx_hold_request = 1'b1;
		for (n = 0; n < 30; n++)
			send_request(n % 3 == 0 ? sle_pkg::OP_POP_LAST : sle_pkg::OP_APPEND,
				pick_value(1'b0), 8'd0);
	endtask

	// Random phases with changing sender and receiver pacing
	task automatic test_random_mix;
		int phase;
		int phase_len;
		int n;
		while (items_sent < 1350) begin
			phase = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 80);
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_stalls_on = $urandom_range(0, 3) != 0;
			for (n = 0; n < phase_len; n++)
				send_random(phase);
		end
	endtask

	// Receiver: stall pattern of runs, long hold on request
	always @(posedge clk) begin
		if (rx_hold_request) begin
			rx_hold_left = 400;
			rx_hold_request = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!rx_stalls_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_run_left == 0) begin
				rx_ready_phase = !rx_ready_phase;
				rx_run_left = rx_ready_phase ? $urandom_range(1, 8) : $urandom_range(1, 5);
			end
			rx_run_left--;
			m_axis_tready <= rx_ready_phase;
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = sle_pkg::status_t'(m_axis_tuser);
			got.found = m_axis_tdata[0];
			got.found_index = m_axis_tdata[6:1];
			got.count = m_axis_tdata[13:7];
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: status %0d found %0d index %0d count %0d",
						got.status, got.found, got.found_index, got.count);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.found !== want.found ||
						got.found_index !== want.found_index || got.count !== want.count) begin
					if (mismatch_count < 10)
						$display("mismatch: expected status %0d found %0d index %0d count %0d, %s",
							want.status, want.found, want.found_index, want.count,
							$sformatf("got status %0d found %0d index %0d count %0d",
								got.status, got.found, got.found_index, got.count));
					mismatch_count++;
				end
			end
		end
	end

	// Hang guard
	initial begin
		#400ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		list_len = 0;
		mismatch_count = 0;
		items_sent = 0;
		tx_gaps_on = 1'b1;
		tx_burst_left = 0;
		rx_stalls_on = 1'b1;
		rx_hold_request = 1'b0;
		rx_hold_left = 0;
		rx_run_left = 0;
		rx_ready_phase = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_list();
		test_edge_values();
		test_full_list();
		test_back_pressure();
		test_random_mix();

		// Drain outstanding results
		s_axis_tvalid <= 1'b0;
		rx_stalls_on = 1'b1;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sequential_list_engine_unit.f =====
rtl/sle_pkg.sv
rtl/sequential_list_engine_unit.sv
tb/sv/testbench.sv
